@@ rtl/core/lrufr_pkg.sv @@
`default_nettype none
package lrufr_pkg;

   localparam int NUM_FRAMES = 16;
   localparam int FRAME_W    = 4;
   localparam int SLOT_COUNT = 1 << FRAME_W;
   localparam int CELL_COUNT = (NUM_FRAMES < SLOT_COUNT) ? NUM_FRAMES : SLOT_COUNT;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

   typedef enum logic [1:0] {
      OP_VICTIM = 2'd0,
      OP_PIN    = 2'd1,
      OP_UNPIN  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef struct packed {
      logic               pin_en;
      logic               unpin_en;
      logic [FRAME_W-1:0] frame;
   } cell_cmd_type;

endpackage
`default_nettype wire

@@ rtl/core/lrufr_if.sv @@
`default_nettype none
interface lrufr_req_if import lrufr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [FRAME_W-1:0] frame_index;

   modport source (output valid, output opcode, output frame_index, input ready);
   modport sink   (input valid, input opcode, input frame_index, output ready);
endinterface

interface lrufr_rsp_if import lrufr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               victim_found;
   logic [FRAME_W-1:0] victim_frame;
   logic [CNT_W-1:0]   tracked_count;

   modport source (output valid, output victim_found, output victim_frame,
                   output tracked_count, input ready);
   modport sink   (input valid, input victim_found, input victim_frame,
                   input tracked_count, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lrufr_cell.sv @@
`default_nettype none
module lrufr_cell import lrufr_pkg::*; (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire cell_cmd_type       cmd,
   input  wire logic               occupied,
   input  wire logic               prev_occupied,
   input  wire logic               shift_in,
   input  wire logic [FRAME_W-1:0] next_entry,
   output logic                    shift_out,
   output logic [FRAME_W-1:0]      entry
);

   logic [FRAME_W-1:0] entry_ff;
   logic [FRAME_W-1:0] entry_in;
   logic               match;

   // a match here or upstream closes the gap by pulling from the next cell
   assign match     = cmd.pin_en && occupied && (entry_ff == cmd.frame);
   assign shift_out = shift_in || match;
   assign entry     = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (shift_out) begin
         entry_in = next_entry;
      end else if (cmd.unpin_en && !occupied && prev_occupied) begin
         entry_in = cmd.frame;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         entry_ff <= entry_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/lru_frame_replacer.sv @@
// LRU frame replacer.
// req carries an opcode (victim, pin, unpin, nop) and a frame index; rsp returns one
// word per request: victim_found, victim_frame and tracked_count after the step.
// The list sits in a row of cells, oldest at cell 0; a removal shifts every
// cell at or past the removed entry one place toward the head, an unpin writes
// the first free cell. All of this completes in the cycle the request is taken.
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one request per cycle; req.ready stays high while the response
// register is empty or being taken. While the receiver stalls, the word waits
// in the response register and req.ready stays low until it is taken.
// Reset clears the membership map, the entry count and the response register;
// no clearing pass is needed and a request is taken in the first cycle after.
`default_nettype none
module lru_frame_replacer import lrufr_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   lrufr_req_if.sink   req,
   lrufr_rsp_if.source rsp
);

   logic [SLOT_COUNT-1:0] member_ff, member_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff;
   logic                  found_ff;
   logic [FRAME_W-1:0]    vframe_ff;

   logic                  accept;
   logic                  is_victim, is_pin, is_unpin;
   logic                  frame_member, do_victim, do_pin, do_unpin;
   cell_cmd_type          cmd;

   logic [FRAME_W-1:0]    entry_w [CELL_COUNT];
   logic [CELL_COUNT:0]   shift_w;
   logic [CELL_COUNT:0]   occ_w;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign is_victim = (req.opcode == OP_VICTIM);
   assign is_pin    = (req.opcode == OP_PIN);
   assign is_unpin  = (req.opcode == OP_UNPIN);

   assign frame_member = member_ff[req.frame_index];
   assign do_victim    = is_victim && (count_ff != '0);
   assign do_pin       = is_pin && frame_member;
   assign do_unpin     = is_unpin && !frame_member && (count_ff < CNT_W'(CELL_COUNT));

   assign cmd.pin_en   = do_pin;
   assign cmd.unpin_en = do_unpin;
   assign cmd.frame    = req.frame_index;

   assign shift_w[0] = do_victim;
   assign occ_w[0]   = 1'b1;

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      logic [FRAME_W-1:0] next_entry;

      assign occ_w[i+1] = (count_ff > CNT_W'(i));
      if (i == CELL_COUNT - 1) begin : g_tail
         assign next_entry = entry_w[i];
      end else begin : g_body
         assign next_entry = entry_w[i+1];
      end

      lrufr_cell u_cell (
         .clock         (clock),
         .enable        (accept),
         .cmd           (cmd),
         .occupied      (occ_w[i+1]),
         .prev_occupied (occ_w[i]),
         .shift_in      (shift_w[i]),
         .next_entry    (next_entry),
         .shift_out     (shift_w[i+1]),
         .entry         (entry_w[i])
      );
   end

   always_comb begin
      member_in = member_ff;
      count_in  = count_ff;
      if (do_victim) begin
         member_in[entry_w[0]] = 1'b0;
         count_in              = count_ff - CNT_W'(1);
      end else if (do_pin) begin
         member_in[req.frame_index] = 1'b0;
         count_in                   = count_ff - CNT_W'(1);
      end else if (do_unpin) begin
         member_in[req.frame_index] = 1'b1;
         count_in                   = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         member_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            member_ff <= member_in;
            count_ff  <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff  <= do_victim;
         vframe_ff <= do_victim ? entry_w[0] : '0;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.victim_found  = found_ff;
   assign rsp.victim_frame  = vframe_ff;
   assign rsp.tracked_count = count_ff;

endmodule
`default_nettype wire
